// ===== src/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and constants for the double-ended priority queue.
// ----------------------------------------------------------------------------
package depq_pkg;

  localparam int CAPACITY = 256;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] value_t;
  typedef logic [CNT_W-1:0]        count_t;

  localparam logic [2:0] REQ_INSERT  = 3'd0;
  localparam logic [2:0] REQ_DEL_MAX = 3'd1;
  localparam logic [2:0] REQ_DEL_MIN = 3'd2;
  localparam logic [2:0] REQ_CLEAR   = 3'd3;
  localparam logic [2:0] REQ_REPORT  = 3'd4;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_SHIFT
  } cell_op_e;

endpackage

// ===== src/double_ended_priority_queue_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_unit
// Sorted row of cells, ascending from cell 0; a fill count marks the end.
// Latency: the result word is strobed on done_o in the cycle after start.
// Throughput: one request per cycle; every cell updates in a single step.
// busy_o is tied low; the row never holds off a request.
// Reset clears the fill count, the strobe and the stored largest value; the cell values are left as is.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_unit
  import depq_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  output logic         busy_o,
  input  logic [2:0]   req_type_i,
  input  value_t       value_i,
  output logic         done_o,
  output logic         is_empty_o,
  output logic         insert_dropped_o,
  output count_t       held_count_o,
  output value_t       largest_value_o,
  output value_t       smallest_value_o
);

  count_t   count_q, count_d;
  logic     done_q;
  logic     dropped_q, dropped_d;
  value_t   largest_q, largest_d;
  logic     accept;
  logic     full;
  logic     empty;
  cell_op_e op;

  logic   [CAPACITY-1:0] gt;
  logic   [CAPACITY-1:0] occupied;
  value_t                cell_value [CAPACITY];
  logic   [IDX_W-1:0]    next_top_idx;
  count_t                next_top_cnt;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;
  assign full   = (count_q == count_t'(CAPACITY));
  assign empty  = (count_q == '0);

  // slot just below the current top
  assign next_top_cnt = count_q - count_t'(2);
  assign next_top_idx = next_top_cnt[IDX_W-1:0];

  always_comb begin
    op        = OP_HOLD;
    count_d   = count_q;
    dropped_d = 1'b0;
    largest_d = largest_q;
    if (accept) begin
      case (req_type_i)
        REQ_INSERT: begin
          if (full) begin
            dropped_d = 1'b1;
          end else begin
            op      = OP_INSERT;
            count_d = count_q + count_t'(1);
            if (empty || (value_i > largest_q)) begin
              largest_d = value_i;
            end
          end
        end
        REQ_DEL_MAX: begin
          if (!empty) begin
            count_d   = count_q - count_t'(1);
            largest_d = cell_value[next_top_idx];
          end
        end
        REQ_DEL_MIN: begin
          if (!empty) begin
            op      = OP_SHIFT;
            count_d = count_q - count_t'(1);
          end
        end
        REQ_CLEAR:  count_d = '0;
        REQ_REPORT: count_d = count_q;
        default:    count_d = count_q;
      endcase
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign occupied[i] = (count_t'(i) < count_q);
    depq_cell u_cell (
      .clk_i         (clk_i),
      .op_i          (op),
      .ins_value_i   (value_i),
      .occupied_i    (occupied[i]),
      .lower_gt_i    ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i-1]),
      .lower_value_i (cell_value[(i == 0) ? 0 : i-1]),
      .upper_value_i (cell_value[(i == CAPACITY-1) ? i : i+1]),
      .gt_o          (gt[i]),
      .value_o       (cell_value[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      done_q    <= 1'b0;
      largest_q <= '0;
    end else begin
      count_q   <= count_d;
      done_q    <= accept;
      largest_q <= largest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dropped_q <= dropped_d;
  end

  assign done_o           = done_q;
  assign is_empty_o       = empty;
  assign insert_dropped_o = dropped_q;
  assign held_count_o     = count_q;
  assign largest_value_o  = empty ? value_t'(0) : largest_q;
  assign smallest_value_o = empty ? value_t'(0) : cell_value[0];

endmodule

// ===== src/depq_cell.sv =====
// ----------------------------------------------------------------------------
// depq_cell
// One slot of the sorted row: holds a value, keeps it, takes the new value,
// or takes a neighbor's value on insert and remove-smallest.
// ----------------------------------------------------------------------------
module depq_cell
  import depq_pkg::*;
(
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  value_t   ins_value_i,
  input  logic     occupied_i,
  input  logic     lower_gt_i,
  input  value_t   lower_value_i,
  input  value_t   upper_value_i,
  output logic     gt_o,
  output value_t   value_o
);

  value_t value_q, value_d;

  // past the end, or above the new value: this slot moves up
  assign gt_o = !occupied_i || (value_q > ins_value_i);

  always_comb begin
    value_d = value_q;
    case (op_i)
      OP_INSERT: begin
        if (gt_o) begin
          value_d = lower_gt_i ? lower_value_i : ins_value_i;
        end
      end
      OP_SHIFT: value_d = upper_value_i;
      default:  value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

// ===== src/depq_checker.sv =====
// ----------------------------------------------------------------------------
// depq_checker
// Port-level checks for the double-ended priority queue, bound to the top.
// ----------------------------------------------------------------------------
module depq_checker
  import depq_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic [2:0] req_type_i,
  input logic       done_o,
  input logic       is_empty_o,
  input logic       insert_dropped_o,
  input count_t     held_count_o,
  input value_t     largest_value_o,
  input value_t     smallest_value_o
);

  a_done_follows_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> done_o)
    else $error("no result word after accepted request");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start_i && !busy_o) |=> !done_o)
    else $error("result word without a request");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && is_empty_o) |->
      (held_count_o == '0 && largest_value_o == '0 && smallest_value_o == '0))
    else $error("empty queue reports values");

  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !is_empty_o) |->
      (held_count_o != '0 && largest_value_o >= smallest_value_o))
    else $error("largest below smallest");

  a_drop_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && req_type_i == REQ_INSERT) |=>
      (insert_dropped_o == ($past(held_count_o) == count_t'(CAPACITY))))
    else $error("drop flag does not match fill");

endmodule

bind double_ended_priority_queue_unit depq_checker u_depq_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start_i          (start_i),
  .busy_o           (busy_o),
  .req_type_i       (req_type_i),
  .done_o           (done_o),
  .is_empty_o       (is_empty_o),
  .insert_dropped_o (insert_dropped_o),
  .held_count_o     (held_count_o),
  .largest_value_o  (largest_value_o),
  .smallest_value_o (smallest_value_o)
);

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the double-ended priority queue. A driver sends
// request words from a pending list with random gaps, and a monitor predicts
// each result from a sorted copy of the held values and checks every field of
// each strobed word. The stimulus covers a directed part, random mixes, a fill
// past capacity, churn near full, and a drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import depq_pkg::*;

  typedef struct {
    logic [2:0]  kind;
    value_t      value;
    int unsigned gap;
  } req_word_t;

  typedef struct packed {
    logic   is_empty;
    logic   dropped;
    count_t count;
    value_t largest;
    value_t smallest;
  } queue_status_t;

  logic       clk_i            = 1'b0;
  logic       rst_ni           = 1'b0;
  logic       start_i          = 1'b0;
  logic [2:0] req_type_i       = REQ_REPORT;
  value_t     value_i          = '0;
  logic       busy_o;
  logic       done_o;
  logic       is_empty_o;
  logic       insert_dropped_o;
  count_t     held_count_o;
  value_t     largest_value_o;
  value_t     smallest_value_o;

  double_ended_priority_queue_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .req_type_i       (req_type_i),
    .value_i          (value_i),
    .done_o           (done_o),
    .is_empty_o       (is_empty_o),
    .insert_dropped_o (insert_dropped_o),
    .held_count_o     (held_count_o),
    .largest_value_o  (largest_value_o),
    .smallest_value_o (smallest_value_o)
  );

  req_word_t     pending_words[$];
  queue_status_t status_expected[$];
  value_t        held_vals[$];

  logic        word_taken    = 1'b0;
  int unsigned gap_left      = 0;
  bit          steady_run    = 1'b0;
  int unsigned mismatch_cnt  = 0;
  int unsigned checked_cnt   = 0;
  int unsigned refused_cnt   = 0;
  int unsigned peak_held     = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // sorted model of the held values, ascending
  function automatic queue_status_t apply_request(logic [2:0] kind, value_t v);
    queue_status_t s;
    int            pos;
    s.dropped = 1'b0;
    case (kind)
      REQ_INSERT: begin
        if (held_vals.size() >= CAPACITY) begin
          s.dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < held_vals.size() && held_vals[pos] <= v) pos++;
          held_vals.insert(pos, v);
        end
      end
      REQ_DEL_MAX: begin
        if (held_vals.size() > 0) void'(held_vals.pop_back());
      end
      REQ_DEL_MIN: begin
        if (held_vals.size() > 0) void'(held_vals.pop_front());
      end
      REQ_CLEAR: begin
        held_vals.delete();
      end
      default: ;
    endcase
    s.is_empty = (held_vals.size() == 0);
    s.count    = count_t'(held_vals.size());
    s.largest  = s.is_empty ? value_t'(0) : held_vals[held_vals.size() - 1];
    s.smallest = s.is_empty ? value_t'(0) : held_vals[0];
    return s;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  function automatic value_t rand_value();
    case ($urandom_range(0, 9))
      0:       return value_t'(32'h8000_0000);
      1:       return value_t'(32'h7fff_ffff);
      2:       return value_t'(-int'($urandom_range(0, 1)));
      3, 4:    return value_t'(int'($urandom_range(0, 8)) - 4);
      default: return value_t'($urandom);
    endcase
  endfunction

  function automatic logic [2:0] rand_kind();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return REQ_INSERT;
    if (r < 62) return REQ_DEL_MAX;
    if (r < 79) return REQ_DEL_MIN;
    if (r < 82) return REQ_CLEAR;
    return REQ_REPORT | 3'($urandom_range(0, 3));
  endfunction

  task automatic add_word(input logic [2:0] kind, input value_t v);
    req_word_t w;
    w.kind  = kind;
    w.value = v;
    w.gap   = pick_gap();
    pending_words.push_back(w);
  endtask

  // driver
  always @(negedge clk_i) begin : driver
    req_word_t w;
    if (!rst_ni) begin
      start_i <= 1'b0;
    end else if (start_i && !word_taken) begin
    end else if (gap_left != 0) begin
      start_i  <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_words.size() != 0) begin
      w = pending_words.pop_front();
      start_i    <= 1'b1;
      req_type_i <= w.kind;
      value_i    <= w.value;
      gap_left   <= w.gap;
    end else begin
      start_i <= 1'b0;
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin : monitor
    queue_status_t got;
    queue_status_t want;
    if (!rst_ni) begin
      word_taken <= 1'b0;
    end else begin
      if (done_o) begin
        got = '{is_empty_o, insert_dropped_o, held_count_o,
                largest_value_o, smallest_value_o};
        if (got.dropped) refused_cnt++;
        if (held_count_o > peak_held) peak_held = held_count_o;
        if (status_expected.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t: result word with nothing pending: empty=%0b drop=%0b cnt=%0d max=%0d min=%0d",
                     $realtime, got.is_empty, got.dropped, got.count, got.largest,
                     got.smallest);
        end else begin
          want = status_expected.pop_front();
          checked_cnt++;
          if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) begin
              $display("%0t: mismatch, expected empty=%0b drop=%0b cnt=%0d max=%0d min=%0d",
                       $realtime, want.is_empty, want.dropped, want.count, want.largest,
                       want.smallest);
              $display("%0t:          actual   empty=%0b drop=%0b cnt=%0d max=%0d min=%0d",
                       $realtime, got.is_empty, got.dropped, got.count, got.largest,
                       got.smallest);
            end
          end
        end
      end
      if (start_i && !busy_o) status_expected.push_back(apply_request(req_type_i, value_i));
      word_taken <= start_i && !busy_o;
    end
  end

  initial begin
    #(2_000_000);
    $display("tb_top failed");
    $finish;
  end

  initial begin : stimulus
    int unsigned leftover;
    // directed part
    add_word(REQ_REPORT, value_t'(32'h1234_5678));
    add_word(REQ_DEL_MAX, value_t'(32'hffff_ffff));
    add_word(REQ_DEL_MIN, value_t'(32'h8000_0000));
    add_word(REQ_INSERT, value_t'(32'h7fff_ffff));
    add_word(REQ_INSERT, value_t'(32'h8000_0000));
    add_word(REQ_INSERT, value_t'(0));
    add_word(REQ_INSERT, value_t'(-1));
    add_word(REQ_INSERT, value_t'(0));
    add_word(REQ_INSERT, value_t'(32'h5555_5555));
    add_word(REQ_INSERT, value_t'(32'haaaa_aaaa));
    add_word(REQ_REPORT | 3'd1, value_t'(32'hffff_ffff));
    add_word(REQ_REPORT | 3'd2, value_t'(0));
    add_word(REQ_REPORT | 3'd3, value_t'(32'h7fff_ffff));
    add_word(REQ_DEL_MAX, value_t'(5));
    add_word(REQ_DEL_MIN, value_t'(-5));
    add_word(REQ_DEL_MAX, value_t'(0));
    add_word(REQ_CLEAR, value_t'(32'h8000_0000));
    add_word(REQ_DEL_MIN, value_t'(0));
    add_word(REQ_INSERT, value_t'(1));
    add_word(REQ_INSERT, value_t'(1));
    add_word(REQ_DEL_MIN, value_t'(0));
    add_word(REQ_DEL_MAX, value_t'(0));
    add_word(REQ_REPORT, value_t'(0));

    // random mix
    for (int i = 0; i < 150; i++) begin
      if (i % 50 == 0) steady_run = ($urandom_range(0, 3) == 0);
      add_word(rand_kind(), rand_value());
    end

    // fill past capacity
    add_word(REQ_CLEAR, rand_value());
    for (int i = 0; i < CAPACITY + 12; i++) begin
      if (i % 50 == 0) steady_run = ($urandom_range(0, 3) == 0);
      add_word(($urandom_range(0, 19) == 0) ? REQ_REPORT : REQ_INSERT, rand_value());
    end

    // churn around full
    for (int i = 0; i < 40; i++) begin
      if ($urandom_range(0, 9) < 6) add_word(REQ_INSERT, rand_value());
      else add_word($urandom_range(0, 1) ? REQ_DEL_MAX : REQ_DEL_MIN, rand_value());
    end

    // partial drain, then clear
    for (int i = 0; i < 60; i++)
      add_word($urandom_range(0, 1) ? REQ_DEL_MAX : REQ_DEL_MIN, rand_value());
    add_word(REQ_CLEAR, rand_value());

    for (int i = 0; i < 200; i++) begin
      if (i % 50 == 0) steady_run = ($urandom_range(0, 3) == 0);
      add_word(rand_kind(), rand_value());
    end

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_words.size() != 0 || start_i || status_expected.size() != 0)
      @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    leftover = status_expected.size();
    if (leftover != 0) $display("%0d expected words never arrived", leftover);
    $display("checked %0d result words, %0d inserts refused on a full queue",
             checked_cnt, refused_cnt);
    $display("peak fill %0d of %0d, %0d mismatches", peak_held, CAPACITY, mismatch_cnt);
    if (mismatch_cnt == 0 && leftover == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

// ===== double_ended_priority_queue_unit.f =====
src/depq_pkg.sv
src/depq_cell.sv
src/double_ended_priority_queue_unit.sv
src/depq_checker.sv
test/tb_top.sv
